// ----- design/spmd_pkg.sv -----
// Shared types and constants for the scan pad / median / pixel block.
package spmd_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int IMAGE_WIDTH = 256;
    localparam int MAX_RESULTS = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAD_PER_SIDE  = 3'd0,
        CFG_DROP_INTERVAL = 3'd1,
        CFG_DROP_COUNT    = 3'd2,
        CFG_WINDOW_SIZE   = 3'd3,
        CFG_MAX_RANGE_MM  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        last_in_scan;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] column;
        logic       last_column;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LEAD,
        ST_SAMPLE,
        ST_TLOAD,
        ST_TRAIL,
        ST_MED,
        ST_DINIT,
        ST_DIV,
        ST_EMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic start;       // latch drop target, clear result count
        logic load_pad;    // load padding counter
        logic feed;        // push one padded position
        logic feed_zero;   // the position is padding
        logic med_step;    // shift sorted window by one entry
        logic div_init;
        logic div_step;
        logic emit;
        logic scan_reset;
    } t_cmd;

    typedef struct packed {
        logic pad_zero;
        logic feed_close;
        logic med_done;
        logic div_last;
        logic emit_ok;
        logic last;
    } t_stat;

endpackage

// ----- design/scan_pad_median_downsample_to_pixels_core.sv -----
// Top level: range samples in, one grey pixel per median window out.
//
//  channel  | signals                               | dir
//  ---------+---------------------------------------+-----
//  input    | i_in_valid, o_in_ready, i_in_item     | in
//  output   | o_out_valid, i_out_ready, o_out_item  | out
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data       | in
//
// One item at a time: ready returns once an accepted sample has been fed, and it also
// waits for the leading padding before the first sample and for the trailing padding
// after the last sample of a scan (the padding per side is clipped).
// Each window of n samples that closes adds the shift-out of the sorted window,
// divider setup, an 8-step restoring divider and emit.
// Reset is synchronous; a finished pixel waits in the output register and stalls
// the sequencer only when the next pixel is ready before it is taken.
module scan_pad_median_downsample_to_pixels_core import spmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    t_cmd  cmd;
    t_stat stat;
    logic  idle;
    logic  in_acc;

    assign o_in_ready = idle;
    assign in_acc     = i_in_valid && idle;

    spmd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_acc(in_acc),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_idle  (idle)
    );

    spmd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_acc   (in_acc),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

endmodule

// ----- design/spmd_ctrl.sv -----
// Sequencer for padding, sample feed, median extraction, divide and emit.
module spmd_ctrl import spmd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_acc,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_idle
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_lead_done, n_lead_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ret       <= ST_IDLE;
            r_lead_done <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_lead_done <= n_lead_done;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_lead_done = r_lead_done;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_acc) n_state = ST_START;
            end
            ST_START: n_state = r_lead_done ? ST_SAMPLE : ST_LEAD;
            ST_LEAD: begin
                if (i_stat.pad_zero) begin
                    n_state     = ST_SAMPLE;
                    n_lead_done = 1'b1;
                end else if (i_stat.feed_close) begin
                    n_state = ST_MED;
                    n_ret   = ST_LEAD;
                end
            end
            ST_SAMPLE: begin
                n_ret   = i_stat.last ? ST_TLOAD : ST_DONE;
                n_state = i_stat.feed_close ? ST_MED : n_ret;
            end
            ST_TLOAD: n_state = ST_TRAIL;
            ST_TRAIL: begin
                if (i_stat.pad_zero) begin
                    n_state = ST_DONE;
                end else if (i_stat.feed_close) begin
                    n_state = ST_MED;
                    n_ret   = ST_TRAIL;
                end
            end
            ST_MED: begin
                if (i_stat.med_done) n_state = ST_DINIT;
            end
            ST_DINIT: n_state = ST_DIV;
            ST_DIV: begin
                if (i_stat.div_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.emit_ok) n_state = r_ret;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
                if (i_stat.last) n_lead_done = 1'b0;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_idle = 1'b0;
        unique case (r_state)
            ST_IDLE: o_idle = 1'b1;
            ST_START: begin
                o_cmd.start    = 1'b1;
                o_cmd.load_pad = 1'b1;
            end
            ST_LEAD, ST_TRAIL: begin
                o_cmd.feed      = !i_stat.pad_zero;
                o_cmd.feed_zero = 1'b1;
            end
            ST_SAMPLE: o_cmd.feed     = 1'b1;
            ST_TLOAD:  o_cmd.load_pad = 1'b1;
            ST_MED:    o_cmd.med_step = 1'b1;
            ST_DINIT:  o_cmd.div_init = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_EMIT:   o_cmd.emit     = i_stat.emit_ok;
            ST_DONE:   o_cmd.scan_reset = i_stat.last;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- design/spmd_dpath.sv -----
// Datapath: config, position/drop tracking, sorted window, divider, output register.
module spmd_dpath import spmd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_acc,
    input  t_in_item              i_in_item,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    // configuration
    logic [9:0]  r_pad;
    logic [13:0] r_iv;
    logic [7:0]  r_dcnt;
    logic [4:0]  r_wsz;
    logic [15:0] r_mx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad  <= '0;
            r_iv   <= 14'd1;
            r_dcnt <= '0;
            r_wsz  <= 5'd4;
            r_mx   <= 16'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PAD_PER_SIDE:  r_pad  <= i_cfg_data[9:0];
                CFG_DROP_INTERVAL: r_iv   <= i_cfg_data[13:0];
                CFG_DROP_COUNT:    r_dcnt <= i_cfg_data[7:0];
                CFG_WINDOW_SIZE:   r_wsz  <= i_cfg_data[4:0];
                CFG_MAX_RANGE_MM:  r_mx   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [4:0]  w_eff;
    logic [13:0] iv_eff;
    logic [15:0] mx_eff;
    logic [10:0] pad_lim;
    logic [9:0]  pad_eff;

    always_comb begin
        w_eff = r_wsz;
        if (r_wsz == 5'd0) w_eff = 5'd1;
        if (r_wsz > 5'(WINDOW_MAX)) w_eff = 5'(WINDOW_MAX);
        iv_eff  = (r_iv == '0) ? 14'd1 : r_iv;
        mx_eff  = (r_mx == '0) ? 16'd1 : r_mx;
        pad_lim = ({w_eff, 6'd0}) - {6'd0, w_eff};
        pad_eff = ({1'b0, r_pad} < pad_lim) ? r_pad : pad_lim[9:0];
    end

    // item latch
    t_in_item r_item;
    always_ff @(posedge i_clk) begin
        if (i_in_acc) r_item <= i_in_item;
    end

    // position, drops, padding counter
    logic [13:0] r_pos;
    logic [7:0]  r_drops;
    logic [21:0] r_next_drop;
    logic [9:0]  r_pad_cnt;
    logic [8:0]  drops_p1;
    logic [22:0] drop_prod;
    logic        is_drop;

    assign drops_p1  = {1'b0, r_drops} + 9'd1;
    assign drop_prod = drops_p1 * iv_eff;
    assign is_drop   = (r_drops < r_dcnt) && ({8'd0, r_pos} == r_next_drop);

    // sorted window
    logic [15:0] r_sw [WINDOW_MAX];
    logic [4:0]  r_fill;
    logic [15:0] feed_val;
    logic [WINDOW_MAX-1:0] le;
    logic [4:0]  fill_p1;

    assign feed_val = i_cmd.feed_zero ? 16'd0 : r_item.range_mm;
    assign fill_p1  = r_fill + 5'd1;

    always_comb begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            le[j] = (5'(j) < r_fill) && (r_sw[j] <= feed_val);
        end
    end

    // median extraction
    logic [4:0]  r_med_n;
    logic [3:0]  r_k;
    logic [15:0] r_lo;
    logic [15:0] r_med;
    logic [3:0]  lo_idx;
    logic [3:0]  hi_idx;
    logic [15:0] lo_val;
    logic [16:0] med_sum;

    assign lo_idx  = 4'((r_med_n - 5'd1) >> 1);
    assign hi_idx  = 4'(r_med_n >> 1);
    assign lo_val  = (r_k == lo_idx) ? r_sw[0] : r_lo;
    assign med_sum = {1'b0, lo_val} + {1'b0, r_sw[0]};

    // divider: quotient of 255*(mx-m) by mx fits 8 bits
    logic [23:0] r_rem;
    logic [22:0] r_dvs;
    logic [7:0]  r_q;
    logic [2:0]  r_dcnt_div;
    logic [15:0] diff;
    logic        rem_ge;

    assign diff   = mx_eff - r_med;
    assign rem_ge = r_rem >= {1'b0, r_dvs};

    // output and column
    logic [7:0] r_col;
    logic [6:0] r_nres;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       cap_full;
    logic       out_free;

    assign cap_full = (r_nres >= 7'(MAX_RESULTS));
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_drops     <= '0;
            r_fill      <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_nres      <= '0;
            r_pad_cnt   <= '0;
        end else begin
            if (i_cmd.emit && !cap_full) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_cmd.start) r_nres <= '0;
            if (i_cmd.load_pad) r_pad_cnt <= pad_eff;
            if (i_cmd.feed) begin
                r_pos <= r_pos + 14'd1;
                if (i_cmd.feed_zero) r_pad_cnt <= r_pad_cnt - 10'd1;
                if (is_drop) begin
                    r_drops <= r_drops + 8'd1;
                end else if (fill_p1 >= w_eff) begin
                    r_fill <= '0;
                end else begin
                    r_fill <= fill_p1;
                end
            end
            if (i_cmd.emit) begin
                r_col <= r_col + 8'd1;
                if (!cap_full) r_nres <= r_nres + 7'd1;
            end
            if (i_cmd.scan_reset) begin
                r_pos   <= '0;
                r_drops <= '0;
                r_fill  <= '0;
                r_col   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) r_next_drop <= drop_prod[21:0];
        if (i_cmd.feed && is_drop) r_next_drop <= r_next_drop + {8'd0, iv_eff};
        if (i_cmd.feed && !is_drop) begin
            for (int j = 0; j < WINDOW_MAX; j++) begin
                if (!le[j]) begin
                    if (j == 0) r_sw[j] <= feed_val;
                    else if (le[j-1]) r_sw[j] <= feed_val;
                    else r_sw[j] <= r_sw[j-1];
                end
            end
            r_med_n <= fill_p1;
            r_k     <= '0;
        end
        if (i_cmd.med_step) begin
            for (int j = 0; j < WINDOW_MAX - 1; j++) r_sw[j] <= r_sw[j+1];
            r_k  <= r_k + 4'd1;
            r_lo <= lo_val;
            if (r_k == hi_idx) r_med <= med_sum[16:1];
        end
        if (i_cmd.div_init) begin
            r_rem      <= (r_med > mx_eff) ? 24'd0 : ({diff, 8'd0} - {8'd0, diff});
            r_dvs      <= {mx_eff, 7'd0};
            r_dcnt_div <= 3'd7;
        end
        if (i_cmd.div_step) begin
            if (rem_ge) r_rem <= r_rem - {1'b0, r_dvs};
            r_q        <= {r_q[6:0], rem_ge};
            r_dvs      <= r_dvs >> 1;
            r_dcnt_div <= r_dcnt_div - 3'd1;
        end
        if (i_cmd.emit && !cap_full) begin
            r_out.pixel       <= r_q;
            r_out.column      <= r_col;
            r_out.last_column <= (r_col == 8'(IMAGE_WIDTH - 1));
        end
    end

    always_comb begin
        o_stat.pad_zero   = (r_pad_cnt == '0);
        o_stat.feed_close = !is_drop && (fill_p1 >= w_eff);
        o_stat.med_done   = (r_k == hi_idx);
        o_stat.div_last   = (r_dcnt_div == '0);
        o_stat.emit_ok    = cap_full || out_free;
        o_stat.last       = r_item.last_in_scan;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
